[sv/bfiq_pkg.sv]
// Shared types and constants of the bloom filter insert/query block.
// Used by the front end, the back end and the top level; depends on nothing.
package bfiq_pkg;

    localparam int STORE_BYTES = 8192;
    localparam int MAX_PROBES  = 32;
    localparam int STORE_WORDS = STORE_BYTES / 8;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int POS_W       = $clog2(STORE_BYTES * 8);
    localparam int NB_W        = POS_W + 1;
    localparam int HASH_W      = 64;
    localparam int KIND_W      = 2;
    localparam int K_W         = 6;
    localparam int BYTES_W     = 14;
    localparam int IDX_W       = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PROBE_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FILTER_BYTES = 2'd1;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
    } item_t;

    // effective configuration seen by the back end
    typedef struct packed {
        logic [K_W-1:0]  probes;
        logic [NB_W-1:0] nbits;
    } cfg_t;

endpackage

[sv/bfiq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bfiq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/bfiq_front.sv]
// Front end: accepts input items, decodes the kind and queues them.
// Depends on bfiq_pkg.
module bfiq_front
    import bfiq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*HASH_W-1:0] s_tdata,   // hash_first, hash_second
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    input  logic                clearing,
    output logic                q_valid,
    output item_t               q_item,
    input  logic                q_pop
);

    item_t      fifo_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    // classify
    always_comb
    begin
        in_item.h1 = s_tdata[HASH_W-1:0];
        in_item.h2 = s_tdata[2*HASH_W-1:HASH_W];
        case (s_tuser)
            KIND_INSERT: in_item.op = OP_INSERT;
            KIND_QUERY:  in_item.op = OP_QUERY;
            KIND_CLEAR:  in_item.op = OP_CLEAR;
            default:     in_item.op = OP_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_reg[rptr_reg];

    // queue pointers
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= in_item;
        end
    end

endmodule

[sv/bfiq_back.sv]
// Back end: reduces the hashes modulo the bit count, walks the probes over
// the bit store, runs clearing sweeps and holds the result register.
// Depends on bfiq_pkg and bfiq_ram.
module bfiq_back
    import bfiq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  clearing,
    output logic  m_valid,
    input  logic  m_ready,
    output logic  m_present
);

    localparam int DIV_CW = $clog2(HASH_W);
    localparam int SQ_W   = $clog2(MAX_PROBES * MAX_PROBES) + 1;
    localparam int I_W    = K_W - 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DIVFIN,
        S_ADD,
        S_FIX,
        S_READ,
        S_CHECK,
        S_STEP,
        S_RES
    } state_t;

    function automatic logic [NB_W-1:0] mod_shift(input logic [NB_W-1:0] r,
                                                  input logic b,
                                                  input logic [NB_W-1:0] n);
        logic [NB_W:0] t;
        t = {r, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[NB_W-1:0];
    endfunction

    function automatic logic [NB_W-1:0] add_mod(input logic [NB_W-1:0] a,
                                                input logic [NB_W-1:0] b,
                                                input logic [NB_W-1:0] n);
        logic [NB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n})
        begin
            s = s - {1'b0, n};
        end
        return s[NB_W-1:0];
    endfunction

    function automatic logic [NB_W-1:0] sub_mod(input logic [NB_W-1:0] a,
                                                input logic [NB_W-1:0] c,
                                                input logic [NB_W-1:0] n);
        logic [NB_W:0] s;
        if (a >= c)
        begin
            s = {1'b0, a} - {1'b0, c};
        end
        else
        begin
            s = {1'b0, a} + {1'b0, n} - {1'b0, c};
        end
        return s[NB_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic [WORD_AW-1:0] clr_reg, clr_next;
    op_t               op_reg, op_next;
    logic [HASH_W-1:0] sh1_reg, sh1_next;
    logic [HASH_W-1:0] sh2_reg, sh2_next;
    logic [HASH_W-1:0] h2_reg, h2_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [DIV_CW-1:0] dcnt_reg, dcnt_next;
    logic [NB_W-1:0]   r1_reg, r1_next;
    logic [NB_W-1:0]   r2_reg, r2_next;
    logic [NB_W-1:0]   ro_reg, ro_next;
    logic [NB_W-1:0]   wrap_reg, wrap_next;
    logic [NB_W-1:0]   accr_reg, accr_next;
    logic [NB_W-1:0]   sqr_reg, sqr_next;
    logic [NB_W-1:0]   dr_reg, dr_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [I_W-1:0]    i_reg, i_next;
    logic [NB_W-1:0]   u_reg, u_next;
    logic              cy_reg, cy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              pres_reg, pres_next;
    logic              mv_reg, mv_next;
    logic              mp_reg, mp_next;

    logic                ram_we;
    logic [WORD_AW-1:0]  ram_waddr;
    logic [HASH_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [HASH_W-1:0]   ram_rdata;
    logic                cur_bit;
    logic [HASH_W:0]     sum65;
    logic [NB_W-1:0]     ones1;

    bfiq_ram #(
        .WIDTH(HASH_W),
        .DEPTH(STORE_WORDS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(pos_reg[POS_W-1:6]),
        .rdata(ram_rdata)
    );

    assign clearing  = (state_reg == S_CLEAR);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign m_valid   = mv_reg;
    assign m_present = mp_reg;
    assign cur_bit   = ram_rdata[pos_reg[5:0]];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        sh1_next   = sh1_reg;
        sh2_next   = sh2_reg;
        h2_next    = h2_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        ro_next    = ro_reg;
        wrap_next  = wrap_reg;
        accr_next  = accr_reg;
        sqr_next   = sqr_reg;
        dr_next    = dr_reg;
        sq_next    = sq_reg;
        i_next     = i_reg;
        u_next     = u_reg;
        cy_next    = cy_reg;
        pos_next   = pos_reg;
        pres_next  = pres_reg;
        mv_next    = (mv_reg && !m_ready);
        mp_next    = mp_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg[POS_W-1:6];
        ram_wdata  = ram_rdata | (HASH_W'(1) << pos_reg[5:0]);
        ram_re     = 1'b0;
        sum65      = '0;
        ones1      = '0;

        case (state_reg)
            // zero the store one word a cycle
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + WORD_AW'(1);
                if (clr_reg == {WORD_AW{1'b1}})
                begin
                    state_next = init_reg ? S_IDLE : S_RES;
                    init_next  = 1'b0;
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next   = q_item.op;
                    sh1_next  = q_item.h1;
                    sh2_next  = q_item.h2;
                    h2_next   = q_item.h2;
                    acc_next  = q_item.h1;
                    dcnt_next = '0;
                    r1_next   = '0;
                    r2_next   = '0;
                    ro_next   = '0;
                    pres_next = 1'b0;
                    case (q_item.op)
                        OP_INSERT, OP_QUERY: state_next = S_DIV;
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:   state_next = S_RES;
                    endcase
                end
            end

            // restoring remainder, one bit a cycle, three lanes
            S_DIV:
            begin
                r1_next   = mod_shift(r1_reg, sh1_reg[HASH_W-1], cfg.nbits);
                r2_next   = mod_shift(r2_reg, sh2_reg[HASH_W-1], cfg.nbits);
                ro_next   = mod_shift(ro_reg, 1'b1, cfg.nbits);
                sh1_next  = sh1_reg << 1;
                sh2_next  = sh2_reg << 1;
                dcnt_next = dcnt_reg + DIV_CW'(1);
                if (dcnt_reg == {DIV_CW{1'b1}})
                begin
                    state_next = S_DIVFIN;
                end
            end

            // wrap term: 2^64 mod n
            S_DIVFIN:
            begin
                ones1     = add_mod(ro_reg, NB_W'(1), cfg.nbits);
                wrap_next = ones1;
                accr_next = r1_reg;
                sqr_next  = '0;
                dr_next   = NB_W'(1);
                sq_next   = '0;
                i_next    = '0;
                pres_next = (op_reg == OP_QUERY);
                state_next = S_ADD;
            end

            // acc + i*i, residue and 64-bit carry
            S_ADD:
            begin
                sum65      = {1'b0, acc_reg} + (HASH_W + 1)'(sq_reg);
                cy_next    = sum65[HASH_W];
                u_next     = add_mod(accr_reg, sqr_reg, cfg.nbits);
                state_next = S_FIX;
            end

            S_FIX:
            begin
                if (cy_reg)
                begin
                    pos_next = POS_W'(sub_mod(u_reg, wrap_reg, cfg.nbits));
                end
                else
                begin
                    pos_next = POS_W'(u_reg);
                end
                state_next = S_READ;
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    ram_we = 1'b1;
                end
                if (op_reg == OP_QUERY && !cur_bit)
                begin
                    pres_next  = 1'b0;
                    state_next = S_RES;
                end
                else if (K_W'(i_reg) + K_W'(1) >= cfg.probes)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    sum65      = {1'b0, acc_reg} + {1'b0, h2_reg};
                    acc_next   = sum65[HASH_W-1:0];
                    cy_next    = sum65[HASH_W];
                    accr_next  = add_mod(accr_reg, r2_reg, cfg.nbits);
                    sq_next    = sq_reg + SQ_W'({i_reg, 1'b1});
                    sqr_next   = add_mod(sqr_reg, dr_reg, cfg.nbits);
                    dr_next    = add_mod(dr_reg, NB_W'(2), cfg.nbits);
                    i_next     = i_reg + I_W'(1);
                    state_next = S_STEP;
                end
            end

            // take off the wrap term after a 64-bit carry
            S_STEP:
            begin
                if (cy_reg)
                begin
                    accr_next = sub_mod(accr_reg, wrap_reg, cfg.nbits);
                end
                state_next = S_ADD;
            end

            S_RES:
            begin
                if (!mv_reg || m_ready)
                begin
                    mv_next    = 1'b1;
                    mp_next    = pres_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        sh1_reg  <= sh1_next;
        sh2_reg  <= sh2_next;
        h2_reg   <= h2_next;
        acc_reg  <= acc_next;
        dcnt_reg <= dcnt_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        ro_reg   <= ro_next;
        wrap_reg <= wrap_next;
        accr_reg <= accr_next;
        sqr_reg  <= sqr_next;
        dr_reg   <= dr_next;
        sq_reg   <= sq_next;
        i_reg    <= i_next;
        u_reg    <= u_next;
        cy_reg   <= cy_next;
        pos_reg  <= pos_next;
        pres_reg <= pres_next;
        mp_reg   <= mp_next;
    end

endmodule

[sv/bloom_filter_insert_query.sv]
// Bloom filter insert/query top level: one item at a time. Insert or query
// reduces the hashes in a 64-step remainder unit, then walks each probe through
// the add, fix, read and check states, with a step state between probes; a clear
// zeroes one store word a cycle, an unused kind goes straight to the result.
// One result item per input item. After reset a clearing pass runs before any
// item is accepted; configuration writes are taken throughout.
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*HASH_W-1:0] s_tdata,   // hash_first, hash_second
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // maybe_present, zero pad
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [BYTES_W-1:0]  cfg_data
);

    logic [K_W-1:0]     probe_count_reg;
    logic [BYTES_W-1:0] filter_bytes_reg;
    cfg_t               cfg;
    logic               q_valid;
    item_t              q_item;
    logic               q_pop;
    logic               clearing;
    logic               present;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_count_reg  <= K_W'(7);
            filter_bytes_reg <= BYTES_W'(STORE_BYTES);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROBE_COUNT:  probe_count_reg  <= cfg_data[K_W-1:0];
                REG_FILTER_BYTES: filter_bytes_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp to legal probe count and size
    always_comb
    begin
        if (probe_count_reg == '0)
        begin
            cfg.probes = K_W'(1);
        end
        else if (probe_count_reg > K_W'(MAX_PROBES))
        begin
            cfg.probes = K_W'(MAX_PROBES);
        end
        else
        begin
            cfg.probes = probe_count_reg;
        end
        if (filter_bytes_reg == '0)
        begin
            cfg.nbits = NB_W'(8);
        end
        else if (filter_bytes_reg > BYTES_W'(STORE_BYTES))
        begin
            cfg.nbits = NB_W'(STORE_BYTES * 8);
        end
        else
        begin
            cfg.nbits = {filter_bytes_reg[NB_W-4:0], 3'b000};
        end
    end

    bfiq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .clearing(clearing),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bfiq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_present(present)
    );

    assign m_tdata = {7'b0, present};

endmodule

[dv/bloom_filter_insert_query_test.sv]
// Self-checking testbench for the bloom filter insert/query block.
// Directed stimulus table, then random phases checked against a behavioral bit store.
// Depends on bfiq_pkg and bloom_filter_insert_query.
module bloom_filter_insert_query_test;
    import bfiq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0]  REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0]  REG_SPARE_HI = 2'd3;
    localparam int LIMIT_CYCLES = 10000000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int N_ROWS = 29;
    localparam int N_PHASES = 14;
    localparam int PHASE_ITEMS = 120;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [2*HASH_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [BYTES_W-1:0]  cfg_data;

    bloom_filter_insert_query i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block state
    bit             filter_bits [0:STORE_BYTES*8-1];
    logic [K_W-1:0] probes_reg;
    logic [BYTES_W-1:0] bytes_reg;
    bit             present_q [$];

    int  errors;
    int  cycles;
    int  n_items;
    int  n_results;
    int  n_hits;
    int  n_cfg;
    bit  no_idle;

    typedef struct {
        bit                is_cfg;
        logic [IDX_W-1:0]  idx;
        logic [BYTES_W-1:0] val;
        logic [KIND_W-1:0] kind;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        bit                typed;
        bit                present;
    } stim_row_t;

    stim_row_t stim_table [0:N_ROWS-1];

    // Clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Filter behavior: update bits, return query answer
    function automatic bit filter_lookup(logic [KIND_W-1:0] kind, logic [HASH_W-1:0] h1,
                                         logic [HASH_W-1:0] h2);
        longint unsigned acc;
        longint unsigned pos;
        longint unsigned nb;
        longint unsigned ii;
        int k;
        bit hit;
        k = (probes_reg == 0) ? 1 : ((probes_reg > MAX_PROBES) ? MAX_PROBES : probes_reg);
        nb = (bytes_reg == 0) ? 1 : ((bytes_reg > STORE_BYTES) ? STORE_BYTES : bytes_reg);
        nb = nb * 8;
        acc = h1;
        hit = 1'b0;
        if (kind == KIND_INSERT)
        begin
            for (int i = 0; i < k; i++)
            begin
                ii = i;
                pos = (acc + ii * ii) % nb;
                filter_bits[pos] = 1'b1;
                acc = acc + h2;
            end
        end
        else if (kind == KIND_QUERY)
        begin
            hit = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                ii = i;
                pos = (acc + ii * ii) % nb;
                if (!filter_bits[pos])
                begin
                    hit = 1'b0;
                    break;
                end
                acc = acc + h2;
            end
        end
        else if (kind == KIND_CLEAR)
        begin
            foreach (filter_bits[j])
                filter_bits[j] = 1'b0;
        end
        return hit;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Send one input item; valid stays high for a back-to-back item
    task automatic send_item(logic [KIND_W-1:0] kind, logic [HASH_W-1:0] h1,
                             logic [HASH_W-1:0] h2, bit typed, bit present);
        int gap;
        bit pred;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {h2, h1};
        do
            @(posedge clk);
        while (!s_tready);
        pred = filter_lookup(kind, h1, h2);
        present_q.push_back(typed ? present : pred);
        n_items++;
    endtask

    // Wait until every result has come back and the block is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (present_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write, only while idle
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [BYTES_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PROBE_COUNT)
            probes_reg = val[K_W-1:0];
        else if (idx == REG_FILTER_BYTES)
            bytes_reg = val;
        n_cfg++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (present_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result item with nothing expected, maybe_present=%0d",
                             m_tdata[0]);
            end
            else
            begin
                if (m_tdata[0] !== present_q[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d maybe_present expected %0d got %0d",
                                 n_results, present_q[0], m_tdata[0]);
                end
                if (present_q[0])
                    n_hits++;
                void'(present_q.pop_front());
            end
        end
    end

    // Receiver stalls
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed stimulus table
    initial
    begin
        stim_table = '{
            '{0, 0, 0, KIND_QUERY,  64'h0, 64'h0, 1, 0},                  // empty after reset
            '{0, 0, 0, KIND_QUERY,  '1, '1, 1, 0},
            '{0, 0, 0, KIND_INSERT, 64'h0, 64'h0, 1, 0},
            '{0, 0, 0, KIND_QUERY,  64'h0, 64'h0, 0, 0},
            '{0, 0, 0, KIND_INSERT, '1, '1, 1, 0},
            '{0, 0, 0, KIND_QUERY,  '1, '1, 0, 0},
            '{0, 0, 0, KIND_UNUSED, 64'h1234_5678_9abc_def0, 64'h77, 1, 0}, // ignored kind
            '{0, 0, 0, KIND_QUERY,  64'h1234_5678_9abc_def0, 64'h77, 0, 0},
            '{0, 0, 0, KIND_CLEAR,  '1, '1, 1, 0},
            '{0, 0, 0, KIND_QUERY,  64'h0, 64'h0, 1, 0},                  // cleared store
            '{1, REG_PROBE_COUNT, 14'd0, 0, 0, 0, 0, 0},                  // zero probes
            '{0, 0, 0, KIND_INSERT, 64'h5, 64'h3, 1, 0},
            '{0, 0, 0, KIND_QUERY,  64'h5, 64'h3, 0, 0},
            '{1, REG_PROBE_COUNT, 14'd63, 0, 0, 0, 0, 0},                 // saturates
            '{0, 0, 0, KIND_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 1, 0},
            '{0, 0, 0, KIND_QUERY,  64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 0, 0},
            '{1, REG_FILTER_BYTES, 14'd0, 0, 0, 0, 0, 0},                 // one byte
            '{0, 0, 0, KIND_INSERT, 64'h123, 64'h456, 1, 0},
            '{0, 0, 0, KIND_QUERY,  64'h999, 64'h1, 0, 0},
            '{1, REG_FILTER_BYTES, 14'h3fff, 0, 0, 0, 0, 0},              // saturates
            '{1, REG_PROBE_COUNT, 14'd32, 0, 0, 0, 0, 0},
            '{0, 0, 0, KIND_INSERT, '1, 64'h1, 1, 0},
            '{0, 0, 0, KIND_QUERY,  '1, 64'h1, 0, 0},
            '{1, REG_SPARE_LO, 14'h2aaa, 0, 0, 0, 0, 0},                  // unused index
            '{1, REG_SPARE_HI, 14'h1555, 0, 0, 0, 0, 0},
            '{0, 0, 0, KIND_QUERY,  '1, 64'h1, 0, 0},
            '{1, REG_FILTER_BYTES, 14'd8192, 0, 0, 0, 0, 0},
            '{1, REG_PROBE_COUNT, 14'd1, 0, 0, 0, 0, 0},
            '{0, 0, 0, KIND_QUERY,  64'h8000_0000_0000_0000, 64'h0, 0, 0}
        };
    end

    // Main sequence
    initial
    begin
        logic [HASH_W-1:0] keys_h1 [$];
        logic [HASH_W-1:0] keys_h2 [$];
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        int r;
        int j;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_INSERT;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        probes_reg = 7;
        bytes_reg  = 8192;
        foreach (filter_bits[i])
            filter_bits[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                write_reg(stim_table[i].idx, stim_table[i].val);
            else
                send_item(stim_table[i].kind, stim_table[i].h1, stim_table[i].h2,
                          stim_table[i].typed, stim_table[i].present);
        end

        // Random phases: insert/query pairs of keys, plus noise
        for (int p = 0; p < N_PHASES; p++)
        begin
            no_idle = (p % 4 == 3);
            r = $urandom_range(0, 5);
            write_reg(REG_PROBE_COUNT, (r == 0) ? 14'd0 : (r == 1) ? 14'd32 :
                      (r == 2) ? 14'd1 : 14'($urandom_range(0, 16383)));
            r = $urandom_range(0, 7);
            write_reg(REG_FILTER_BYTES, (r == 0) ? 14'd8192 : (r == 1) ? 14'h3fff :
                      (r == 2) ? 14'd0 : (r == 3) ? 14'($urandom_range(0, 16383)) :
                      14'($urandom_range(1, 64)));
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                          14'($urandom_range(0, 16383)));
            keys_h1.delete();
            keys_h2.delete();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 199);
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
                if (r < 2)
                    send_item(KIND_CLEAR, a, b, 0, 0);
                else if (r < 6)
                    send_item(KIND_UNUSED, a, b, 0, 0);
                else if (r < 90)
                begin
                    send_item(KIND_INSERT, a, b, 0, 0);
                    keys_h1.push_back(a);
                    keys_h2.push_back(b);
                end
                else if (r < 160 && keys_h1.size() > 0)
                begin
                    j = $urandom_range(0, keys_h1.size() - 1);
                    send_item(KIND_QUERY, keys_h1[j], keys_h2[j], 0, 0);
                end
                else
                    send_item(KIND_QUERY, a, b, 0, 0);
                // hold off until the block has drained
                if (n == PHASE_ITEMS / 2 && p % 3 == 0)
                    wait_idle();
            end
        end

        // Drain
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (present_q.size() != 0)
        begin
            errors++;
            $display("ERROR: %0d result items never arrived", present_q.size());
        end
        $display("Sent %0d items over %0d register writes; %0d results, %0d present.",
                 n_items, n_cfg, n_results, n_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
sv/bfiq_pkg.sv
sv/bfiq_ram.sv
sv/bfiq_front.sv
sv/bfiq_back.sv
sv/bloom_filter_insert_query.sv
dv/bloom_filter_insert_query_test.sv
